>>> rtl/slcp_pkg.sv
package slcp_pkg;
	localparam int COLUMNS_DEF = 64;
	localparam int WORD_W = 64;
	localparam int PASS_W = 13;
	localparam logic [PASS_W-1:0] PASS_MAX = '1;
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_PROP = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t set_off;
		word_t set_on;
		word_t sig_off;
		word_t sig_on;
		logic abort;
	} flags_t;

	function automatic word_t rot_up(input word_t x);
		return {x[WORD_W-2:0], x[WORD_W-1]};
	endfunction

	function automatic word_t rot_dn(input word_t x);
		return {x[0], x[WORD_W-1:1]};
	endfunction
endpackage

>>> rtl/slcp_rules.sv
module slcp_rules (
	input  slcp_pkg::word_t st_prev,
	input  slcp_pkg::word_t st_cur,
	input  slcp_pkg::word_t st_next,
	input  slcp_pkg::word_t kn_prev,
	input  slcp_pkg::word_t kn_cur,
	input  slcp_pkg::word_t kn_next,
	output slcp_pkg::flags_t flags
);
	import slcp_pkg::*;

	word_t oa, ob, oc, ua, ub, uc;
	word_t ola, oha, olb, ohb, olc, ohc, ula, uha, ulb, uhb, ulc, uhc;
	word_t o0, o1, o2, o3, u0, u1, u2, u3;
	word_t st, uk, ns, nk, so, sn, go, gn, ab;

	function automatic word_t c3lo(input word_t a);
		return rot_up(a) ^ rot_dn(a) ^ a;
	endfunction

	function automatic word_t c3hi(input word_t a);
		return ((rot_up(a) ^ rot_dn(a)) & a) | (rot_up(a) & rot_dn(a));
	endfunction

	always_comb begin
		word_t s0, k0, t, s1, s2, k1, k2;
		ola = c3lo(st_prev); oha = c3hi(st_prev);
		olb = c3lo(st_next); ohb = c3hi(st_next);
		olc = c3lo(st_cur);  ohc = c3hi(st_cur);
		ula = c3lo(~kn_prev); uha = c3hi(~kn_prev);
		ulb = c3lo(~kn_next); uhb = c3hi(~kn_next);
		ulc = c3lo(~kn_cur);  uhc = c3hi(~kn_cur);
		s0 = ola ^ olc; k0 = ola & olc; t = oha ^ ohc; s1 = t ^ k0;
		s2 = (oha & ohc) | (k0 & t);
		o0 = s0 ^ olb; k1 = s0 & olb; t = s1 ^ ohb; o1 = t ^ k1;
		k2 = (s1 & ohb) | (k1 & t); o2 = s2 ^ k2; o3 = s2 & k2;
		s0 = ula ^ ulc; k0 = ula & ulc; t = uha ^ uhc; s1 = t ^ k0;
		s2 = (uha & uhc) | (k0 & t);
		u0 = s0 ^ ulb; k1 = s0 & ulb; t = s1 ^ uhb; u1 = t ^ k1;
		k2 = (s1 & uhb) | (k1 & t); u2 = s2 ^ k2; u3 = s2 & k2;
		st = st_cur; uk = ~kn_cur; ns = ~st; nk = kn_cur;
		so = (nk & ns & ~o2 & o1 & ~o0 & ~u2 & ~u1 & u0)
			| (nk & ns & ~o2 & o1 & o0 & ~u2 & ~u1)
			| (ns & ~o1 & ~o0 & ~u2 & u1 & ~u0)
			| (ns & ~o1 & ~u3 & ~u2 & ~u1 & u0)
			| (ns & o2 & (u2 | u0 | u1));
		sn = (uk & ~o2 & o1 & o0 & ~u2 & ~u1 & u0)
			| (st & ~o1 & o0 & ~u2 & u1 & ~u0)
			| (st & ~o2 & ~o0 & ~u3 & ~u2 & ~u1)
			| (st & ~o2 & ~o1 & ~o0 & ~u2 & u1)
			| (st & o2 & (u2 | u0 | u1));
		go = (nk & ns & ~o2 & o1 & ~o0 & ~u2 & ~u1 & u0)
			| (st & o2 & (u2 | u0 | u1));
		gn = (nk & ns & ~o2 & o1 & o0 & ~u2 & ~u1)
			| (st & ~o1 & o0 & ~u2 & u1 & ~u0)
			| (st & ~o2 & ~o0 & ~u3 & ~u2 & ~u1)
			| (st & ~o2 & ~o1 & ~o0 & ~u2 & u1);
		ab = (nk & ns & ~o2 & o1 & o0 & ~u2 & ~u1 & ~u0)
			| (st & o2 & (o0 | o1))
			| (st & ~o2 & ~o0 & ~u3 & ~u2 & ~u1 & ~u0)
			| (st & ~o2 & ~o1 & ~o0 & ~u2 & u1 & ~u0)
			| (st & ~o2 & ~o1 & ~u3 & ~u2 & ~u1);
		flags.set_off = so;
		flags.set_on = sn;
		flags.sig_off = go;
		flags.sig_on = gn;
		flags.abort = |ab;
	end
endmodule

>>> rtl/still_life_constraint_propagator_unit.sv
// Still-life constraint propagator. Write and read requests go through the
// memory read register and then the result register. A propagate request
// runs passes, each a flag sweep over all columns through the shared rule
// unit and then an update sweep that dilates the signal flags and writes
// both planes back; each sweep runs through the read register and the
// column window pipeline. It repeats until the known plane settles or a
// contradiction appears. The grids reset to zero through per-column valid
// bits; no clearing pass is needed.
module still_life_constraint_propagator_unit #(
	parameter int COLUMNS = slcp_pkg::COLUMNS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] req_type,
	input  logic [5:0] column_index,
	input  logic [63:0] stable_word,
	input  logic [63:0] known_word,
	output logic out_valid,
	input  logic out_stall,
	output logic [63:0] stable_out,
	output logic [63:0] known_out,
	output logic consistent,
	output logic [12:0] passes
);
	import slcp_pkg::*;

	localparam int CW = $clog2(COLUMNS);
	localparam int CNTW = $clog2(COLUMNS + 4);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_FLAG = 3'd2;
	localparam logic [2:0] S_UPD = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [CNTW-1:0] cnt_q;
	logic [1:0] req_q;
	logic [CW-1:0] col_q;
	logic inrange_q;
	logic [PASS_W-1:0] pass_q;
	logic abort_q, chg_q;

	word_t st_mem [COLUMNS];
	word_t kn_mem [COLUMNS];
	word_t so_mem [COLUMNS];
	word_t sn_mem [COLUMNS];
	word_t go_mem [COLUMNS];
	word_t gn_mem [COLUMNS];
	logic [COLUMNS-1:0] vld_q;

	word_t st_rd_q, kn_rd_q, so_rd_q, sn_rd_q, go_rd_q, gn_rd_q;
	logic vrd_q;
	word_t st_w_q [3];
	word_t kn_w_q [3];
	word_t go_w_q [3];
	word_t gn_w_q [3];
	word_t sd_q, su_q, fo_q, fn_q;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] wr_col_q;
	logic [CW-1:0] idx_q [2];
	logic rd_en;
	flags_t flags;
	word_t st_eff, kn_eff;

	assign in_stall = (state_q != S_IDLE);
	assign rd_en = 1'b1;
	assign st_eff = vrd_q ? st_rd_q : '0;
	assign kn_eff = vrd_q ? kn_rd_q : '0;

	slcp_rules u_rules (
		.st_prev(st_w_q[2]), .st_cur(st_w_q[1]), .st_next(st_w_q[0]),
		.kn_prev(kn_w_q[2]), .kn_cur(kn_w_q[1]), .kn_next(kn_w_q[0]),
		.flags(flags)
	);

	// read address: request column, or sweep (cnt 0 -> col COLUMNS-1, then 0..)
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = CW'(column_index);
		end else if (state_q inside {S_RD, S_DONE}) begin
			rd_addr = col_q;
		end else if (cnt_q == '0) begin
			rd_addr = CW'(COLUMNS - 1);
		end else if (cnt_q > CNTW'(COLUMNS)) begin
			rd_addr = '0;
		end else begin
			rd_addr = CW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			st_rd_q <= st_mem[rd_addr];
			kn_rd_q <= kn_mem[rd_addr];
			so_rd_q <= so_mem[rd_addr];
			sn_rd_q <= sn_mem[rd_addr];
			go_rd_q <= go_mem[rd_addr];
			gn_rd_q <= gn_mem[rd_addr];
		end
	end

	// window shift and write-back
	always_ff @(posedge clk) begin
		word_t don, doff, dx, fs, nk, uk;
		st_w_q[2] <= st_w_q[1]; st_w_q[1] <= st_w_q[0]; st_w_q[0] <= st_eff;
		kn_w_q[2] <= kn_w_q[1]; kn_w_q[1] <= kn_w_q[0]; kn_w_q[0] <= kn_eff;
		go_w_q[2] <= go_w_q[1]; go_w_q[1] <= go_w_q[0]; go_w_q[0] <= go_rd_q;
		gn_w_q[2] <= gn_w_q[1]; gn_w_q[1] <= gn_w_q[0]; gn_w_q[0] <= gn_rd_q;
		sd_q <= so_rd_q; su_q <= sd_q; fo_q <= sn_rd_q; fn_q <= fo_q;
		idx_q[0] <= rd_addr; idx_q[1] <= idx_q[0];
		wr_col_q <= idx_q[1];
		if (state_q == S_IDLE && in_valid && req_type == REQ_WRITE
				&& {3'b0, column_index} < 9'(COLUMNS)) begin
			st_mem[CW'(column_index)] <= stable_word;
			kn_mem[CW'(column_index)] <= known_word;
		end else if (state_q == S_FLAG && cnt_q >= CNTW'(4)) begin
			so_mem[wr_col_q] <= flags.set_off;
			sn_mem[wr_col_q] <= flags.set_on;
			go_mem[wr_col_q] <= flags.sig_off;
			gn_mem[wr_col_q] <= flags.sig_on;
		end else if (state_q == S_UPD && cnt_q >= CNTW'(4)) begin
			dx = gn_w_q[2] | gn_w_q[1] | gn_w_q[0];
			don = dx | rot_up(dx) | rot_dn(dx);
			dx = go_w_q[2] | go_w_q[1] | go_w_q[0];
			doff = dx | rot_up(dx) | rot_dn(dx);
			uk = ~kn_w_q[1];
			fs = fn_q | su_q;
			nk = kn_w_q[1] | don | doff | (fs & uk);
			st_mem[wr_col_q] <= st_w_q[1] | ((fn_q | don) & uk);
			kn_mem[wr_col_q] <= nk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		word_t dx, don, doff, nk;
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			req_q <= '0;
			col_q <= '0;
			inrange_q <= 1'b0;
			pass_q <= '0;
			abort_q <= 1'b0;
			chg_q <= 1'b0;
			vld_q <= '0;
			vrd_q <= 1'b0;
			out_valid <= 1'b0;
			stable_out <= '0;
			known_out <= '0;
			consistent <= 1'b0;
			passes <= '0;
		end else begin
			vrd_q <= vld_q[rd_addr];
			if (out_valid && !out_stall && state_q != S_DONE) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						col_q <= CW'(column_index);
						inrange_q <= {3'b0, column_index} < 9'(COLUMNS);
						cnt_q <= '0;
						pass_q <= '0;
						abort_q <= 1'b0;
						chg_q <= 1'b0;
						if (req_type == REQ_WRITE && {3'b0, column_index} < 9'(COLUMNS))
							vld_q[CW'(column_index)] <= 1'b1;
						state_q <= (req_type == REQ_PROP) ? S_FLAG : S_RD;
					end
				end
				S_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(1)) state_q <= S_DONE;
				end
				S_FLAG: begin
					if (cnt_q >= CNTW'(4) && flags.abort) abort_q <= 1'b1;
					if (cnt_q == CNTW'(COLUMNS + 3)) begin
						cnt_q <= '0;
						state_q <= S_UPD;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_UPD: begin
					if (cnt_q >= CNTW'(4)) begin
						vld_q[wr_col_q] <= 1'b1;
						dx = gn_w_q[2] | gn_w_q[1] | gn_w_q[0];
						don = dx | rot_up(dx) | rot_dn(dx);
						dx = go_w_q[2] | go_w_q[1] | go_w_q[0];
						doff = dx | rot_up(dx) | rot_dn(dx);
						nk = kn_w_q[1] | don | doff | ((fn_q | su_q) & ~kn_w_q[1]);
						if (nk != kn_w_q[1] && cnt_q != CNTW'(COLUMNS + 3)) chg_q <= 1'b1;
					end
					if (cnt_q == CNTW'(COLUMNS + 3)) begin
						cnt_q <= '0;
						if (pass_q != PASS_MAX) pass_q <= pass_q + 1'b1;
						if (abort_q || !(chg_q || nk != kn_w_q[1])) state_q <= S_DONE;
						else begin
							chg_q <= 1'b0;
							state_q <= S_FLAG;
						end
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						stable_out <= (req_q == REQ_READ && inrange_q) ? st_eff : '0;
						known_out <= (req_q == REQ_READ && inrange_q) ? kn_eff : '0;
						consistent <= (req_q == REQ_PROP) ? !abort_q : 1'b0;
						passes <= (req_q == REQ_PROP) ? pass_q : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && req_q != REQ_PROP |-> passes == '0)
		else $error("pass count on non-propagate");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accepting while busy");
`endif
endmodule
